// ===== rtl/skf_pkg.sv =====
// shared types, codes and constants of the scalar kalman filter
package skf_pkg;

   localparam int DATA_WIDTH_DEF  = 32;
   localparam int FRAC_BITS_DEF   = 16;
   localparam int GAIN_BITS       = 16;
   localparam int GAIN_WIDTH      = GAIN_BITS + 1;
   localparam int CNT_WIDTH       = $clog2(GAIN_BITS + 1);
   localparam int CSR_INDEX_WIDTH = 2;

   localparam logic [GAIN_WIDTH-1:0] GAIN_ONE = GAIN_WIDTH'(1) << GAIN_BITS;

   typedef enum logic [1:0] {
      STAT_OK       = 2'd0,
      STAT_ZERO_DEN = 2'd1,
      STAT_OVERFLOW = 2'd2,
      STAT_HALTED   = 2'd3
   } status_type;

   typedef enum logic [CSR_INDEX_WIDTH-1:0] {
      REG_PROCESS_NOISE     = 2'd0,
      REG_MEASUREMENT_NOISE = 2'd1,
      REG_INIT_ESTIMATE     = 2'd2,
      REG_INIT_COVARIANCE   = 2'd3
   } csr_index_type;

   typedef enum logic [1:0] {
      ALU_ADD = 2'd0,
      ALU_SUB = 2'd1,
      ALU_MUL = 2'd2
   } alu_op_type;

   typedef enum logic [3:0] {
      S_IDLE  = 4'd0,
      S_PRED  = 4'd1,
      S_DEN   = 4'd2,
      S_DIV   = 4'd3,
      S_DIFF  = 4'd4,
      S_NEG   = 4'd5,
      S_MULD  = 4'd6,
      S_UPD   = 4'd7,
      S_ONEMK = 4'd8,
      S_MULP  = 4'd9,
      S_DONE  = 4'd10
   } state_type;

   typedef struct packed {
      logic load_estimate;
      logic load_covariance;
   } csr_load_type;

endpackage

// ===== rtl/skf_intf.sv =====
// measurement and result channel interfaces
interface skf_req_if #(
   parameter int DATA_WIDTH = skf_pkg::DATA_WIDTH_DEF
);
   logic                         valid;
   logic                         ready;
   logic signed [DATA_WIDTH-1:0] measurement;

   modport source (output valid, output measurement, input ready);
   modport sink   (input valid, input measurement, output ready);
endinterface

interface skf_rsp_if #(
   parameter int DATA_WIDTH = skf_pkg::DATA_WIDTH_DEF
);
   logic                              valid;
   logic                              ready;
   logic signed [DATA_WIDTH-1:0]      estimate;
   logic        [DATA_WIDTH-1:0]      error_covariance;
   logic [skf_pkg::GAIN_WIDTH-1:0]    gain;
   logic [1:0]                        status;

   modport source (output valid, output estimate, output error_covariance,
                   output gain, output status, input ready);
   modport sink   (input valid, input estimate, input error_covariance,
                   input gain, input status, output ready);
endinterface

// ===== rtl/skf_alu.sv =====
// shared add, subtract and gain-multiply unit
module skf_alu #(
   parameter int DATA_WIDTH = skf_pkg::DATA_WIDTH_DEF
) (
   input  skf_pkg::alu_op_type    op,
   input  logic [DATA_WIDTH+1:0]  a,
   input  logic [DATA_WIDTH+1:0]  b,
   output logic [DATA_WIDTH+2:0]  res
);
   localparam int AW = DATA_WIDTH + 2;
   localparam int PW = DATA_WIDTH + 1 + skf_pkg::GAIN_WIDTH;

   logic [PW-1:0] prod;

   // gain product, floor(a * b / 2^gain_bits)
   assign prod = PW'(a[DATA_WIDTH:0]) * PW'(b[skf_pkg::GAIN_WIDTH-1:0]);

   always_comb begin
      unique case (op)
         skf_pkg::ALU_ADD: res = {1'b0, a} + {1'b0, b};
         skf_pkg::ALU_SUB: res = {1'b0, a} - {1'b0, b};
         skf_pkg::ALU_MUL: res = (AW+1)'(prod >> skf_pkg::GAIN_BITS);
         default:          res = '0;
      endcase
   end
endmodule

// ===== rtl/skf_core.sv =====
// sequencer and working registers of one filter recursion
module skf_core #(
   parameter int                    DATA_WIDTH = skf_pkg::DATA_WIDTH_DEF,
   parameter logic [DATA_WIDTH-1:0] EST_RESET  = '0,
   parameter logic [DATA_WIDTH-1:0] COV_RESET  = '0
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_ready,
   input  logic [DATA_WIDTH-1:0]               req_measurement,
   output logic                                rsp_valid,
   input  logic                                rsp_ready,
   output logic [DATA_WIDTH-1:0]               rsp_estimate,
   output logic [DATA_WIDTH-1:0]               rsp_error_covariance,
   output logic [skf_pkg::GAIN_WIDTH-1:0]      rsp_gain,
   output logic [1:0]                          rsp_status,
   input  logic [DATA_WIDTH-1:0]               process_noise,
   input  logic [DATA_WIDTH-1:0]               measurement_noise,
   input  skf_pkg::csr_load_type               csr_load,
   input  logic [DATA_WIDTH-1:0]               load_data
);
   localparam int W  = DATA_WIDTH;
   localparam int AW = DATA_WIDTH + 2;
   localparam int GW = skf_pkg::GAIN_WIDTH;
   localparam int CW = skf_pkg::CNT_WIDTH;

   skf_pkg::state_type  state_ff, state_in;
   skf_pkg::status_type status_ff, status_in;
   skf_pkg::alu_op_type alu_op;
   logic [AW-1:0]       alu_a, alu_b;
   logic [AW:0]         alu_res;
   logic                out_load;
   logic                upd_ovf;
   logic [AW-1:0]       div_trial;

   logic [W-1:0]   est_ff, est_in;
   logic [W-1:0]   cov_ff, cov_in;
   logic           halted_ff, halted_in;
   logic [W-1:0]   m_ff, m_in;
   logic [W:0]     p1_ff, p1_in;
   logic [W:0]     den_ff, den_in;
   logic [AW-1:0]  rem_ff, rem_in;
   logic [GW-1:0]  k_ff, k_in;
   logic [CW-1:0]  cnt_ff, cnt_in;
   logic [W:0]     diff_ff, diff_in;
   logic [W:0]     mag_ff, mag_in;
   logic           neg_ff, neg_in;
   logic [W:0]     delta_ff, delta_in;
   logic [W-1:0]   xnew_ff, xnew_in;
   logic [GW-1:0]  omk_ff, omk_in;
   logic [W-1:0]   pnew_ff, pnew_in;

   logic                   rsp_valid_ff, rsp_valid_in;
   logic [W-1:0]           rsp_est_ff, rsp_est_in;
   logic [W-1:0]           rsp_cov_ff, rsp_cov_in;
   logic [GW-1:0]          rsp_gain_ff, rsp_gain_in;
   skf_pkg::status_type    rsp_status_ff, rsp_status_in;

   skf_alu #(.DATA_WIDTH(DATA_WIDTH)) u_alu (
      .op  (alu_op),
      .a   (alu_a),
      .b   (alu_b),
      .res (alu_res)
   );

   // first divide step compares without a shift
   assign div_trial = (cnt_ff == '0) ? rem_ff : {rem_ff[AW-2:0], 1'b0};
   // new estimate must fit the signed data width
   assign upd_ovf = !((alu_res[AW-1:W-1] == '0) || (alu_res[AW-1:W-1] == '1));

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         skf_pkg::S_IDLE:  if (req_valid) begin
            state_in = halted_ff ? skf_pkg::S_DONE : skf_pkg::S_PRED;
         end
         skf_pkg::S_PRED:  state_in = alu_res[W] ? skf_pkg::S_DONE : skf_pkg::S_DEN;
         skf_pkg::S_DEN:   state_in = (alu_res == '0) ? skf_pkg::S_DONE : skf_pkg::S_DIV;
         skf_pkg::S_DIV:   if (cnt_ff == CW'(skf_pkg::GAIN_BITS)) begin
            state_in = skf_pkg::S_DIFF;
         end
         skf_pkg::S_DIFF:  state_in = alu_res[W] ? skf_pkg::S_NEG : skf_pkg::S_MULD;
         skf_pkg::S_NEG:   state_in = skf_pkg::S_MULD;
         skf_pkg::S_MULD:  state_in = skf_pkg::S_UPD;
         skf_pkg::S_UPD:   state_in = upd_ovf ? skf_pkg::S_DONE : skf_pkg::S_ONEMK;
         skf_pkg::S_ONEMK: state_in = skf_pkg::S_MULP;
         skf_pkg::S_MULP:  state_in = skf_pkg::S_DONE;
         skf_pkg::S_DONE:  if (out_load) begin
            state_in = skf_pkg::S_IDLE;
         end
         default:          state_in = skf_pkg::S_IDLE;
      endcase
   end

   // sequencer outputs: handshake and shared unit operands
   always_comb begin
      req_ready = 1'b0;
      out_load  = 1'b0;
      alu_op    = skf_pkg::ALU_ADD;
      alu_a     = '0;
      alu_b     = '0;
      unique case (state_ff)
         skf_pkg::S_IDLE: req_ready = 1'b1;
         skf_pkg::S_PRED: begin
            alu_a = AW'(cov_ff);
            alu_b = AW'(process_noise);
         end
         skf_pkg::S_DEN: begin
            alu_a = AW'(p1_ff);
            alu_b = AW'(measurement_noise);
         end
         skf_pkg::S_DIV: begin
            alu_op = skf_pkg::ALU_SUB;
            alu_a  = div_trial;
            alu_b  = AW'(den_ff);
         end
         skf_pkg::S_DIFF: begin
            alu_op = skf_pkg::ALU_SUB;
            alu_a  = {{2{m_ff[W-1]}}, m_ff};
            alu_b  = {{2{est_ff[W-1]}}, est_ff};
         end
         skf_pkg::S_NEG: begin
            alu_op = skf_pkg::ALU_SUB;
            alu_b  = {diff_ff[W], diff_ff};
         end
         skf_pkg::S_MULD: begin
            alu_op = skf_pkg::ALU_MUL;
            alu_a  = AW'(mag_ff);
            alu_b  = AW'(k_ff);
         end
         skf_pkg::S_UPD: begin
            alu_op = neg_ff ? skf_pkg::ALU_SUB : skf_pkg::ALU_ADD;
            alu_a  = {{2{est_ff[W-1]}}, est_ff};
            alu_b  = AW'(delta_ff);
         end
         skf_pkg::S_ONEMK: begin
            alu_op = skf_pkg::ALU_SUB;
            alu_a  = AW'(skf_pkg::GAIN_ONE);
            alu_b  = AW'(k_ff);
         end
         skf_pkg::S_MULP: begin
            alu_op = skf_pkg::ALU_MUL;
            alu_a  = AW'(p1_ff);
            alu_b  = AW'(omk_ff);
         end
         skf_pkg::S_DONE: out_load = !rsp_valid_ff || rsp_ready;
         default: ;
      endcase
   end

   // working registers
   always_comb begin
      status_in     = status_ff;
      est_in        = est_ff;
      cov_in        = cov_ff;
      halted_in     = halted_ff;
      m_in          = m_ff;
      p1_in         = p1_ff;
      den_in        = den_ff;
      rem_in        = rem_ff;
      k_in          = k_ff;
      cnt_in        = cnt_ff;
      diff_in       = diff_ff;
      mag_in        = mag_ff;
      neg_in        = neg_ff;
      delta_in      = delta_ff;
      xnew_in       = xnew_ff;
      omk_in        = omk_ff;
      pnew_in       = pnew_ff;
      rsp_est_in    = rsp_est_ff;
      rsp_cov_in    = rsp_cov_ff;
      rsp_gain_in   = rsp_gain_ff;
      rsp_status_in = rsp_status_ff;
      rsp_valid_in  = rsp_ready ? 1'b0 : rsp_valid_ff;

      unique case (state_ff)
         skf_pkg::S_IDLE: begin
            m_in      = req_measurement;
            status_in = halted_ff ? skf_pkg::STAT_HALTED : skf_pkg::STAT_OK;
         end
         skf_pkg::S_PRED: begin
            p1_in = alu_res[W:0];
            if (alu_res[W]) begin
               status_in = skf_pkg::STAT_OVERFLOW;
            end
         end
         skf_pkg::S_DEN: begin
            den_in = alu_res[W:0];
            rem_in = AW'(p1_ff);
            k_in   = '0;
            cnt_in = '0;
            if (alu_res == '0) begin
               status_in = skf_pkg::STAT_ZERO_DEN;
            end
         end
         skf_pkg::S_DIV: begin
            cnt_in = cnt_ff + CW'(1);
            if (!alu_res[AW]) begin
               rem_in = alu_res[AW-1:0];
               k_in   = {k_ff[GW-2:0], 1'b1};
            end else begin
               rem_in = div_trial;
               k_in   = {k_ff[GW-2:0], 1'b0};
            end
         end
         skf_pkg::S_DIFF: begin
            diff_in = alu_res[W:0];
            mag_in  = alu_res[W:0];
            neg_in  = alu_res[W];
         end
         skf_pkg::S_NEG:   mag_in = alu_res[W:0];
         skf_pkg::S_MULD:  delta_in = alu_res[W:0];
         skf_pkg::S_UPD: begin
            xnew_in = alu_res[W-1:0];
            if (upd_ovf) begin
               status_in = skf_pkg::STAT_OVERFLOW;
            end
         end
         skf_pkg::S_ONEMK: omk_in = alu_res[GW-1:0];
         skf_pkg::S_MULP: begin
            pnew_in = alu_res[W-1:0];
            if (alu_res[AW:W] != '0) begin
               status_in = skf_pkg::STAT_OVERFLOW;
            end
         end
         skf_pkg::S_DONE: if (out_load) begin
            rsp_valid_in  = 1'b1;
            rsp_status_in = status_ff;
            if (status_ff == skf_pkg::STAT_OK) begin
               est_in      = xnew_ff;
               cov_in      = pnew_ff;
               rsp_est_in  = xnew_ff;
               rsp_cov_in  = pnew_ff;
               rsp_gain_in = k_ff;
            end else begin
               halted_in   = 1'b1;
               rsp_est_in  = est_ff;
               rsp_cov_in  = cov_ff;
               rsp_gain_in = '0;
            end
         end
         default: ;
      endcase

      // reload of the starting values clears the halt
      if (csr_load.load_estimate) begin
         est_in    = load_data;
         halted_in = 1'b0;
      end
      if (csr_load.load_covariance) begin
         cov_in    = load_data;
         halted_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= skf_pkg::S_IDLE;
         rsp_valid_ff <= 1'b0;
         halted_ff    <= 1'b0;
         est_ff       <= EST_RESET;
         cov_ff       <= COV_RESET;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         halted_ff    <= halted_in;
         est_ff       <= est_in;
         cov_ff       <= cov_in;
      end
   end

   always_ff @(posedge clock) begin
      status_ff     <= status_in;
      m_ff          <= m_in;
      p1_ff         <= p1_in;
      den_ff        <= den_in;
      rem_ff        <= rem_in;
      k_ff          <= k_in;
      cnt_ff        <= cnt_in;
      diff_ff       <= diff_in;
      mag_ff        <= mag_in;
      neg_ff        <= neg_in;
      delta_ff      <= delta_in;
      xnew_ff       <= xnew_in;
      omk_ff        <= omk_in;
      pnew_ff       <= pnew_in;
      rsp_est_ff    <= rsp_est_in;
      rsp_cov_ff    <= rsp_cov_in;
      rsp_gain_ff   <= rsp_gain_in;
      rsp_status_ff <= rsp_status_in;
   end

   assign rsp_valid            = rsp_valid_ff;
   assign rsp_estimate         = rsp_est_ff;
   assign rsp_error_covariance = rsp_cov_ff;
   assign rsp_gain             = rsp_gain_ff;
   assign rsp_status           = rsp_status_ff;

`ifndef SYNTHESIS
   a_div_rem_below_den: assert property (@(posedge clock) disable iff (reset)
      (state_ff == skf_pkg::S_DIV && cnt_ff != '0) |-> (rem_ff < AW'(den_ff)))
      else $error("divider remainder not below denominator");

   a_gain_at_most_one: assert property (@(posedge clock) disable iff (reset)
      (state_ff == skf_pkg::S_DIFF) |-> (k_ff <= skf_pkg::GAIN_ONE))
      else $error("gain above one after divide");

   a_error_gain_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_status_ff != skf_pkg::STAT_OK) |-> (rsp_gain_ff == '0))
      else $error("failed step reports nonzero gain");

   a_halt_after_error: assert property (@(posedge clock) disable iff (reset)
      (out_load && status_ff != skf_pkg::STAT_OK && !csr_load.load_estimate
       && !csr_load.load_covariance) |=> halted_ff)
      else $error("halt not set after failed step");
`endif
endmodule

// ===== rtl/scalar_kalman_filter.sv =====
// Scalar Kalman filter, one recursion per measurement transfer.
//
// req_if carries one signed measurement per transfer; rsp_if returns one
// result per measurement: the updated estimate, error covariance, the gain
// used (unsigned Q1.16) and a status code. csr_wr_en writes register
// csr_index (process noise, measurement noise, starting estimate, starting
// covariance) with csr_wr_data; writing either starting value reloads the
// filter state and clears a sticky halt. Write registers only while idle.
//
// A recursion runs a 17-step restoring gain divide on the shared
// add/subtract/multiply unit and adds a negate step when the measurement
// lies below the estimate; a halted filter skips straight to its result.
// A new measurement is taken only in the cycle after the result is
// registered, so one measurement is finished before the next is taken.
//
// Reset is synchronous and restores the default noises and starting state.
// If the receiver stalls, the result waits in the output register; the next
// measurement is still taken and processed, and its result waits for the slot.
module scalar_kalman_filter #(
   parameter int DATA_WIDTH = skf_pkg::DATA_WIDTH_DEF,
   parameter int FRAC_BITS  = skf_pkg::FRAC_BITS_DEF
) (
   input  logic                                  clock,
   input  logic                                  reset,
   skf_req_if.sink                               req_if,
   skf_rsp_if.source                             rsp_if,
   input  logic                                  csr_wr_en,
   input  logic [skf_pkg::CSR_INDEX_WIDTH-1:0]   csr_index,
   input  logic [DATA_WIDTH-1:0]                 csr_wr_data
);
   // 0.1 and 5.0 in the chosen fixed-point format
   localparam logic [DATA_WIDTH-1:0] NOISE_RESET =
      DATA_WIDTH'(((64'd1 << FRAC_BITS) + 64'd5) / 64'd10);
   localparam logic [DATA_WIDTH-1:0] EST_RESET = DATA_WIDTH'(64'd5 << FRAC_BITS);

   logic [DATA_WIDTH-1:0]  q_ff, q_in;
   logic [DATA_WIDTH-1:0]  r_ff, r_in;
   skf_pkg::csr_load_type  csr_load;

   always_comb begin
      q_in     = q_ff;
      r_in     = r_ff;
      csr_load = '0;
      if (csr_wr_en) begin
         unique case (skf_pkg::csr_index_type'(csr_index))
            skf_pkg::REG_PROCESS_NOISE:     q_in = csr_wr_data;
            skf_pkg::REG_MEASUREMENT_NOISE: r_in = csr_wr_data;
            skf_pkg::REG_INIT_ESTIMATE:     csr_load.load_estimate = 1'b1;
            skf_pkg::REG_INIT_COVARIANCE:   csr_load.load_covariance = 1'b1;
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         q_ff <= NOISE_RESET;
         r_ff <= NOISE_RESET;
      end else begin
         q_ff <= q_in;
         r_ff <= r_in;
      end
   end

   skf_core #(
      .DATA_WIDTH (DATA_WIDTH),
      .EST_RESET  (EST_RESET),
      .COV_RESET  (NOISE_RESET)
   ) u_core (
      .clock                (clock),
      .reset                (reset),
      .req_valid            (req_if.valid),
      .req_ready            (req_if.ready),
      .req_measurement      (req_if.measurement),
      .rsp_valid            (rsp_if.valid),
      .rsp_ready            (rsp_if.ready),
      .rsp_estimate         (rsp_if.estimate),
      .rsp_error_covariance (rsp_if.error_covariance),
      .rsp_gain             (rsp_if.gain),
      .rsp_status           (rsp_if.status),
      .process_noise        (q_ff),
      .measurement_noise    (r_ff),
      .csr_load             (csr_load),
      .load_data            (csr_wr_data)
   );
endmodule

// ===== test/tb_top.sv =====
// testbench for scalar_kalman_filter: directed table, then predictor-checked random items
module tb_top;

   localparam int DW                = skf_pkg::DATA_WIDTH_DEF;
   localparam int IDLE_LIMIT        = 2000;
   localparam int SETTINGS_PER_MODE = 5;
   localparam int ITEMS_PER_SETTING = 65;
   localparam int RESULT_LATENCY    = 40;
   localparam int MAX_REPORTS       = 50;

   localparam longint EST_MIN = -(longint'(1) <<< (DW - 1));
   localparam longint EST_MAX = (longint'(1) <<< (DW - 1)) - 1;

   typedef struct packed {
      logic signed [DW-1:0]            estimate;
      logic [DW-1:0]                   error_covariance;
      logic [skf_pkg::GAIN_WIDTH-1:0]  gain;
      skf_pkg::status_type             status;
   } filter_update_type;

   typedef enum logic [1:0] {
      ROW_MEAS,
      ROW_KNOWN,
      ROW_CSR
   } row_kind_type;

   typedef struct packed {
      row_kind_type            kind;
      skf_pkg::csr_index_type  index;
      logic [DW-1:0]           value;
      filter_update_type       want;
   } stim_row_type;

   localparam filter_update_type NO_RESULT = '0;

   // known rows: after reset, unit gain across the full range, every error code
   localparam stim_row_type DIRECTED_ROWS [25] = '{
      '{ROW_KNOWN, skf_pkg::REG_PROCESS_NOISE, 32'h0005_0000,
        '{32'sh0005_0000, 32'd4369, 17'd43690, skf_pkg::STAT_OK}},
      '{ROW_MEAS,  skf_pkg::REG_PROCESS_NOISE,     32'h7FFF_FFFF, NO_RESULT},
      '{ROW_MEAS,  skf_pkg::REG_PROCESS_NOISE,     32'h8000_0000, NO_RESULT},
      '{ROW_MEAS,  skf_pkg::REG_PROCESS_NOISE,     32'h0000_0000, NO_RESULT},
      '{ROW_MEAS,  skf_pkg::REG_PROCESS_NOISE,     32'hFFFF_FFFF, NO_RESULT},
      '{ROW_CSR,   skf_pkg::REG_PROCESS_NOISE,     32'h0000_0000, NO_RESULT},
      '{ROW_CSR,   skf_pkg::REG_MEASUREMENT_NOISE, 32'h0000_0000, NO_RESULT},
      '{ROW_CSR,   skf_pkg::REG_INIT_COVARIANCE,   32'h0001_0000, NO_RESULT},
      '{ROW_CSR,   skf_pkg::REG_INIT_ESTIMATE,     32'h7FFF_FFFF, NO_RESULT},
      '{ROW_KNOWN, skf_pkg::REG_PROCESS_NOISE, 32'h8000_0000,
        '{32'sh8000_0000, 32'd0, 17'd65536, skf_pkg::STAT_OK}},
      '{ROW_KNOWN, skf_pkg::REG_PROCESS_NOISE, 32'h1234_5678,
        '{32'sh8000_0000, 32'd0, 17'd0, skf_pkg::STAT_ZERO_DEN}},
      '{ROW_KNOWN, skf_pkg::REG_PROCESS_NOISE, 32'h0000_0000,
        '{32'sh8000_0000, 32'd0, 17'd0, skf_pkg::STAT_HALTED}},
      '{ROW_CSR,   skf_pkg::REG_INIT_COVARIANCE,   32'hFFFF_FFFF, NO_RESULT},
      '{ROW_CSR,   skf_pkg::REG_PROCESS_NOISE,     32'h0000_0001, NO_RESULT},
      '{ROW_KNOWN, skf_pkg::REG_PROCESS_NOISE, 32'h0000_0000,
        '{32'sh8000_0000, 32'hFFFF_FFFF, 17'd0, skf_pkg::STAT_OVERFLOW}},
      '{ROW_KNOWN, skf_pkg::REG_PROCESS_NOISE, 32'h7FFF_FFFF,
        '{32'sh8000_0000, 32'hFFFF_FFFF, 17'd0, skf_pkg::STAT_HALTED}},
      '{ROW_CSR,   skf_pkg::REG_PROCESS_NOISE,     32'h0000_0000, NO_RESULT},
      '{ROW_CSR,   skf_pkg::REG_MEASUREMENT_NOISE, 32'hFFFF_FFFF, NO_RESULT},
      '{ROW_CSR,   skf_pkg::REG_INIT_ESTIMATE,     32'h0000_0000, NO_RESULT},
      '{ROW_MEAS,  skf_pkg::REG_PROCESS_NOISE,     32'h7FFF_FFFF, NO_RESULT},
      '{ROW_MEAS,  skf_pkg::REG_PROCESS_NOISE,     32'h8000_0000, NO_RESULT},
      '{ROW_CSR,   skf_pkg::REG_INIT_COVARIANCE,   32'h0000_0000, NO_RESULT},
      '{ROW_CSR,   skf_pkg::REG_PROCESS_NOISE,     32'hFFFF_FFFF, NO_RESULT},
      '{ROW_MEAS,  skf_pkg::REG_PROCESS_NOISE,     32'h0001_2345, NO_RESULT},
      '{ROW_MEAS,  skf_pkg::REG_PROCESS_NOISE,     32'hFFFF_0000, NO_RESULT}
   };

   logic                   clock = 1'b0;
   logic                   reset;
   logic                   csr_wr_en;
   skf_pkg::csr_index_type csr_index;
   logic [DW-1:0]          csr_wr_data;

   skf_req_if #(.DATA_WIDTH(DW)) req_if ();
   skf_rsp_if #(.DATA_WIDTH(DW)) rsp_if ();

   scalar_kalman_filter uut (
      .clock       (clock),
      .reset       (reset),
      .req_if      (req_if),
      .rsp_if      (rsp_if),
      .csr_wr_en   (csr_wr_en),
      .csr_index   (csr_index),
      .csr_wr_data (csr_wr_data)
   );

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   // predicted filter state and registers
   logic [DW-1:0]        pred_q;
   logic [DW-1:0]        pred_r;
   logic signed [DW-1:0] pred_est;
   logic [DW-1:0]        pred_cov;
   logic                 pred_halted;

   filter_update_type pending_updates [$];
   int send_idle_pct;
   int recv_stall_pct;
   int mismatches;
   int sent_count;
   int checked_count;
   int csr_writes;
   int idle_cycles;
   int status_seen [4];

   function automatic filter_update_type filter_update(input logic signed [DW-1:0] meas);
      logic [DW:0]         p1;
      logic [DW+1:0]       den;
      logic [63:0]         k, mag, delta, pnew;
      longint              x, m, diff, xnew;
      skf_pkg::status_type st;
      filter_update_type   res;
      st = skf_pkg::STAT_OK;
      k  = '0;
      if (pred_halted) begin
         st = skf_pkg::STAT_HALTED;
      end else begin
         p1 = {1'b0, pred_cov} + {1'b0, pred_q};
         if (p1[DW]) begin
            st = skf_pkg::STAT_OVERFLOW;
         end else begin
            den = {1'b0, p1} + {2'b00, pred_r};
            if (den == '0) begin
               st = skf_pkg::STAT_ZERO_DEN;
            end else begin
               k     = (64'(p1) << skf_pkg::GAIN_BITS) / 64'(den);
               x     = pred_est;
               m     = meas;
               diff  = m - x;
               mag   = (diff < 0) ? -diff : diff;
               // truncation toward zero on the correction term
               delta = (mag * k) >> skf_pkg::GAIN_BITS;
               xnew  = (diff < 0) ? x - longint'(delta) : x + longint'(delta);
               pnew  = (64'(p1) * (64'(skf_pkg::GAIN_ONE) - k)) >> skf_pkg::GAIN_BITS;
               if (xnew < EST_MIN || xnew > EST_MAX || (pnew >> DW) != 0) begin
                  st = skf_pkg::STAT_OVERFLOW;
               end else begin
                  pred_est = DW'(xnew);
                  pred_cov = pnew[DW-1:0];
               end
            end
         end
         if (st != skf_pkg::STAT_OK) begin
            pred_halted = 1'b1;
            k = '0;
         end
      end
      res.estimate         = pred_est;
      res.error_covariance = pred_cov;
      res.gain             = k[skf_pkg::GAIN_WIDTH-1:0];
      res.status           = st;
      return res;
   endfunction

   function automatic logic [DW-1:0] pick_noise();
      case ($urandom_range(9))
         0: return '0;
         1: return '1;
         2: return $urandom;
         3: return $urandom_range(32'h00FF_FFFF);
         default: return $urandom_range(32'h0004_0000);
      endcase
   endfunction

   task automatic report_mismatch(input string what, input logic [63:0] got,
                                  input logic [63:0] want);
      mismatches++;
      if (mismatches <= MAX_REPORTS)
         $display("mismatch at %0t: %s got %h expected %h", $time, what, got, want);
   endtask

   task automatic wait_for_results();
      req_if.valid <= 1'b0;
      while (pending_updates.size() != 0)
         @(posedge clock);
   endtask

   // csr_wr_en stays high across back-to-back writes, the next measurement drops it
   task automatic write_csr(input skf_pkg::csr_index_type idx, input logic [DW-1:0] value);
      wait_for_results();
      csr_wr_en   <= 1'b1;
      csr_index   <= idx;
      csr_wr_data <= value;
      @(posedge clock);
      case (idx)
         skf_pkg::REG_PROCESS_NOISE:     pred_q = value;
         skf_pkg::REG_MEASUREMENT_NOISE: pred_r = value;
         skf_pkg::REG_INIT_ESTIMATE: begin
            pred_est    = value;
            pred_halted = 1'b0;
         end
         skf_pkg::REG_INIT_COVARIANCE: begin
            pred_cov    = value;
            pred_halted = 1'b0;
         end
      endcase
      csr_writes++;
   endtask

   task automatic send_measurement(input logic [DW-1:0] meas, input logic known,
                                   input filter_update_type known_update);
      filter_update_type predicted;
      csr_wr_en <= 1'b0;
      while ($urandom_range(99) < send_idle_pct) begin
         req_if.valid <= 1'b0;
         @(posedge clock);
      end
      req_if.valid       <= 1'b1;
      req_if.measurement <= meas;
      do
         @(posedge clock);
      while (!req_if.ready);
      predicted = filter_update(meas);
      pending_updates.push_back(known ? known_update : predicted);
      sent_count++;
   endtask

   // result side: random stalls and the field checks
   always @(posedge clock) begin
      filter_update_type want;
      if (!reset && rsp_if.valid && rsp_if.ready) begin
         status_seen[rsp_if.status]++;
         if (pending_updates.size() == 0) begin
            report_mismatch("result with no measurement outstanding", rsp_if.estimate, '0);
         end else begin
            want = pending_updates.pop_front();
            checked_count++;
            if (rsp_if.estimate !== want.estimate)
               report_mismatch("estimate", rsp_if.estimate, want.estimate);
            if (rsp_if.error_covariance !== want.error_covariance)
               report_mismatch("error_covariance", rsp_if.error_covariance,
                               want.error_covariance);
            if (rsp_if.gain !== want.gain)
               report_mismatch("gain", rsp_if.gain, want.gain);
            if (rsp_if.status !== want.status)
               report_mismatch("status", rsp_if.status, want.status);
         end
      end
      rsp_if.ready <= ($urandom_range(99) >= recv_stall_pct);
   end

   always @(posedge clock) begin
      if (reset || (req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready)) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= IDLE_LIMIT) begin
         $display("watchdog: no transfer for %0d cycles", IDLE_LIMIT);
         $display("Some tests failed");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   initial begin
      logic [DW-1:0] meas;
      reset              <= 1'b1;
      req_if.valid       <= 1'b0;
      req_if.measurement <= '0;
      csr_wr_en          <= 1'b0;
      csr_index          <= skf_pkg::REG_PROCESS_NOISE;
      csr_wr_data        <= '0;
      mismatches         = 0;
      sent_count         = 0;
      checked_count      = 0;
      csr_writes         = 0;
      status_seen        = '{default: 0};
      send_idle_pct      = 10;
      recv_stall_pct     = 10;
      pred_q             = 32'd6554;
      pred_r             = 32'd6554;
      pred_cov           = 32'd6554;
      pred_est           = 32'sd327680;
      pred_halted        = 1'b0;
      repeat (2) @(posedge clock);
      reset <= 1'b0;

      for (int i = 0; i < $size(DIRECTED_ROWS); i++) begin
         case (DIRECTED_ROWS[i].kind)
            ROW_CSR:   write_csr(DIRECTED_ROWS[i].index, DIRECTED_ROWS[i].value);
            ROW_KNOWN: send_measurement(DIRECTED_ROWS[i].value, 1'b1, DIRECTED_ROWS[i].want);
            default:   send_measurement(DIRECTED_ROWS[i].value, 1'b0, NO_RESULT);
         endcase
      end

      for (int mode = 0; mode < 4; mode++) begin
         case (mode)
            0: begin
               send_idle_pct  = 0;
               recv_stall_pct = 0;
            end
            1: begin
               send_idle_pct  = 51;
               recv_stall_pct = 0;
            end
            2: begin
               send_idle_pct  = 0;
               recv_stall_pct = 51;
            end
            default: begin
               send_idle_pct  = 10;
               recv_stall_pct = 10;
            end
         endcase
         for (int setting = 0; setting < SETTINGS_PER_MODE; setting++) begin
            write_csr(skf_pkg::REG_PROCESS_NOISE, pick_noise());
            write_csr(skf_pkg::REG_MEASUREMENT_NOISE, pick_noise());
            write_csr(skf_pkg::REG_INIT_ESTIMATE, $urandom);
            write_csr(skf_pkg::REG_INIT_COVARIANCE, pick_noise());
            for (int n = 0; n < ITEMS_PER_SETTING; n++) begin
               // a reload clears a halt so the run keeps tracking
               if ((pred_halted && $urandom_range(7) == 0) || $urandom_range(49) == 0) begin
                  if ($urandom_range(1) == 1)
                     write_csr(skf_pkg::REG_INIT_ESTIMATE, $urandom);
                  else
                     write_csr(skf_pkg::REG_INIT_COVARIANCE, pick_noise());
               end
               if ($urandom_range(3) == 0)
                  meas = $urandom;
               else
                  meas = pred_est + $urandom_range(32'h0010_0000) - 32'h0008_0000;
               send_measurement(meas, 1'b0, NO_RESULT);
            end
         end
      end

      wait_for_results();
      repeat (RESULT_LATENCY) @(posedge clock);

      $display("covered %0d measurements, %0d results checked, %0d register writes",
               sent_count, checked_count, csr_writes);
      $display("status mix: ok %0d, zero denominator %0d, overflow %0d, halted %0d",
               status_seen[skf_pkg::STAT_OK], status_seen[skf_pkg::STAT_ZERO_DEN],
               status_seen[skf_pkg::STAT_OVERFLOW], status_seen[skf_pkg::STAT_HALTED]);
      if (mismatches == 0)
         $display("All tests passed");
      else
         $display("Some tests failed");
      $finish;
   end

endmodule
